// ===== hw/rtl/nphl_pkg.sv =====
// Shared types and codes for the nearest point height lookup block.
package nphl_pkg;

	localparam int DEF_MAX_POINTS = 256;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
	} cmd_item_t;

	typedef struct packed {
		logic signed [15:0] height;
		logic [7:0]         nearest_index;
		logic               valid_res;
	} res_item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	typedef struct packed {
		logic start;
		logic vld;
		logic last;
	} scan_ctl_t;

endpackage

// ===== hw/rtl/nphl_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module nphl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/nphl_scan.sv =====
// Distance pipeline and running nearest point tracker for the scan.
module nphl_scan import nphl_pkg::*; #(
	parameter int AW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctl_t          ctl,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic [AW-1:0]      idx_s1,
	input  point_t             rdata,
	output logic               fin,
	output logic signed [15:0] best_z,
	output logic [AW-1:0]      best_idx
);

	logic signed [15:0] qx_q, qy_q;
	logic signed [16:0] dx, dy;
	logic signed [33:0] sqx, sqy;
	logic [32:0]        dx2_s2, dy2_s2;
	logic [AW-1:0]      idx_s2;
	logic signed [15:0] z_s2;
	logic               vld_s2, last_s2;
	logic [33:0]        sum;
	logic [33:0]        best_d_q;
	logic               first_q;
	logic               upd;

	assign dx  = 17'(qx_q) - 17'(rdata.x);
	assign dy  = 17'(qy_q) - 17'(rdata.y);
	assign sqx = dx * dx;
	assign sqy = dy * dy;
	assign sum = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign upd = vld_s2 && (first_q || sum <= best_d_q);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			qx_q <= qx;
			qy_q <= qy;
		end
		dx2_s2 <= sqx[32:0];
		dy2_s2 <= sqy[32:0];
		idx_s2 <= idx_s1;
		z_s2   <= rdata.z;
		if (upd) begin
			best_d_q <= sum;
			best_z   <= z_s2;
			best_idx <= idx_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			first_q <= 1'b0;
			fin     <= 1'b0;
		end else begin
			vld_s2  <= ctl.vld;
			last_s2 <= ctl.vld && ctl.last;
			fin     <= vld_s2 && last_s2;
			if (ctl.start) begin
				first_q <= 1'b1;
			end else if (vld_s2) begin
				first_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/nearest_point_height_lookup.sv =====
// Top level of the nearest point height lookup: command decode, point count and result.
//
//  Channel   Signals                     Transfer when
//  command   start, busy, cmd            start high and busy low at a rising edge
//  result    done, res                   done high, one cycle, receiver cannot stall
//  config    cfg_we, cfg_wdata           cfg_we high at a rising edge
//
// Clear and load leave busy low, and the next command may follow at once.
// A query on an empty store answers in the next cycle. Otherwise a query reads the
// point RAM one entry per cycle through the single RAM read port. busy is high for
// the whole scan. Reset empties the store and clears the offset; RAM contents are
// not cleared.
module nearest_point_height_lookup import nphl_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_item_t          cmd,
	output logic               done,
	output res_item_t          res,
	input  logic               cfg_we,
	input  logic signed [15:0] cfg_wdata
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic               issued_all_q;
	logic               vld_s1, last_s1;
	logic [AW-1:0]      idx_s1;
	logic signed [15:0] offset_q;
	logic               accept;
	logic               do_load, do_query;
	logic               issue, issue_last;
	point_t             wpoint, rdata;
	scan_ctl_t          ctl;
	logic               fin;
	logic signed [15:0] best_z;
	logic [AW-1:0]      best_idx;
	logic signed [16:0] diff;

	assign busy       = (state_q == ST_SCAN);
	assign accept     = start && !busy;
	assign do_load    = accept && (cmd.op == OP_LOAD) && (count_q < CW'(MAX_POINTS));
	assign do_query   = accept && (cmd.op == OP_QUERY);
	assign issue      = (state_q == ST_SCAN) && !issued_all_q;
	assign issue_last = (CW'(idx_q) + CW'(1)) == count_q;
	assign wpoint     = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z};
	assign diff       = 17'(best_z) - 17'(offset_q);

	assign ctl = '{start: do_query, vld: vld_s1, last: last_s1};

	nphl_ram #(
		.WIDTH($bits(point_t)),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (do_load),
		.waddr(count_q[AW-1:0]),
		.wdata(wpoint),
		.re   (issue),
		.raddr(idx_q),
		.rdata(rdata)
	);

	nphl_scan #(
		.AW(AW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.qx      (cmd.pos_x),
		.qy      (cmd.pos_y),
		.idx_s1  (idx_s1),
		.rdata   (rdata),
		.fin     (fin),
		.best_z  (best_z),
		.best_idx(best_idx)
	);

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (do_query && count_q == '0) begin
			res <= '{height: '0, nearest_index: '0, valid_res: 1'b0};
		end else if (fin) begin
			res.valid_res     <= 1'b1;
			res.nearest_index <= 8'(best_idx);
			if (diff[16] != diff[15]) begin
				res.height <= diff[16] ? 16'sh8000 : 16'sh7fff;
			end else begin
				res.height <= diff[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			issued_all_q <= 1'b0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
			offset_q     <= '0;
			done         <= 1'b0;
		end else begin
			done    <= 1'b0;
			vld_s1  <= issue;
			last_s1 <= issue && issue_last;
			if (cfg_we) begin
				offset_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd.op == OP_CLEAR) begin
						count_q <= '0;
					end
					if (do_load) begin
						count_q <= count_q + CW'(1);
					end
					if (do_query) begin
						if (count_q == '0) begin
							done <= 1'b1;
						end else begin
							state_q      <= ST_SCAN;
							idx_q        <= '0;
							issued_all_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + AW'(1);
						if (issue_last) begin
							issued_all_q <= 1'b1;
						end
					end
					if (fin) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("Scan ended without a result transfer.");

	a_query_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == OP_QUERY) |=> (busy || done))
		else $error("Query neither started a scan nor answered.");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.valid_res) |-> (res.height == 16'sd0 && res.nearest_index == 8'd0))
		else $error("Empty-store result carries nonzero fields.");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("Point count exceeds capacity.");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest point height lookup block.
module tb import nphl_pkg::*; ();

	localparam int STORE_DEPTH   = DEF_MAX_POINTS;
	localparam int RUN_ITEMS     = 1700;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		cmd_item_t c;
		bit        typed;
		res_item_t r;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cmd_item_t          cmd;
	logic               done;
	res_item_t          res;
	logic               cfg_we;
	logic signed [15:0] cfg_wdata;

	logic signed [15:0] pt_x [STORE_DEPTH];
	logic signed [15:0] pt_y [STORE_DEPTH];
	logic signed [15:0] pt_z [STORE_DEPTH];
	int                 pt_cnt;
	logic signed [15:0] hoff;

	res_item_t answers_q [$];
	dir_row_t  dir_tab [$];
	int        errors = 0;
	int        idle_cycles = 0;
	int        items_sent;

	nearest_point_height_lookup #(
		.MAX_POINTS(STORE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit predict_lookup(input cmd_item_t c, output res_item_t r);
		longint dx;
		longint dy;
		longint d;
		longint best_d;
		int     best;
		int     h;
		int     i;
		predict_lookup = 1'b0;
		r = '0;
		if (c.op == OP_CLEAR) begin
			pt_cnt = 0;
		end else if (c.op == OP_LOAD) begin
			if (pt_cnt < STORE_DEPTH) begin
				pt_x[pt_cnt] = c.pos_x;
				pt_y[pt_cnt] = c.pos_y;
				pt_z[pt_cnt] = c.pos_z;
				pt_cnt++;
			end
		end else if (c.op == OP_QUERY) begin
			predict_lookup = 1'b1;
			if (pt_cnt != 0) begin
				best = 0;
				best_d = 0;
				for (i = 0; i < pt_cnt; i++) begin
					dx = longint'(c.pos_x) - longint'(pt_x[i]);
					dy = longint'(c.pos_y) - longint'(pt_y[i]);
					d = dx * dx + dy * dy;
					// Ties go to the later entry.
					if (i == 0 || d <= best_d) begin
						best_d = d;
						best = i;
					end
				end
				h = int'(pt_z[best]) - int'(hoff);
				if (h > 32767)
					h = 32767;
				if (h < -32768)
					h = -32768;
				r.height = h[15:0];
				r.nearest_index = best[7:0];
				r.valid_res = 1'b1;
			end
		end
	endfunction

	function automatic dir_row_t mk_row(input logic [1:0] op, input int x, input int y,
			input int z, input bit typed, input int h, input int idx, input bit v);
		dir_row_t row;
		row.c.op = op;
		row.c.pos_x = x[15:0];
		row.c.pos_y = y[15:0];
		row.c.pos_z = z[15:0];
		row.typed = typed;
		row.r.height = h[15:0];
		row.r.nearest_index = idx[7:0];
		row.r.valid_res = v;
		return row;
	endfunction

	function automatic logic signed [15:0] pick_coord(input bit pooled);
		logic signed [15:0] pool [8];
		pool = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sd256, -16'sd256,
			16'sd3};
		if (pooled)
			return pool[$urandom_range(0, 7)];
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic add_row(input dir_row_t row);
		dir_tab = {dir_tab, row};
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic issue(input cmd_item_t c, input int gap, input bit typed,
			input res_item_t typed_r);
		res_item_t r;
		bit        has;
		repeat (gap) @(negedge clk) start <= 1'b0;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		has = predict_lookup(c, r);
		if (has)
			answers_q = {answers_q, (typed ? typed_r : r)};
	endtask

	task automatic send_cmd(input cmd_item_t c, input bit burst);
		cmd_item_t noise;
		if ($urandom_range(0, 24) == 0) begin
			noise.op = OP_NOP;
			noise.pos_x = 16'($urandom_range(0, 65535));
			noise.pos_y = 16'($urandom_range(0, 65535));
			noise.pos_z = 16'($urandom_range(0, 65535));
			issue(noise, burst ? 0 : $urandom_range(0, 15), 1'b0, '0);
		end
		issue(c, burst ? 0 : $urandom_range(0, 15), 1'b0, '0);
		items_sent++;
	endtask

	task automatic set_offset(input logic signed [15:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (answers_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		hoff = v;
	endtask

	always @(posedge clk) begin : check_results
		res_item_t e;
		if (arst_n === 1'b1) begin
			if ($isunknown(done)) begin
				report("done is unknown");
			end else if (done) begin
				if (answers_q.size() == 0) begin
					report($sformatf("unexpected result height %0d index %0d valid %0b",
						res.height, res.nearest_index, res.valid_res));
				end else begin
					e = answers_q.pop_front();
					if (res.height !== e.height)
						report($sformatf("height got %0d want %0d", res.height, e.height));
					if (res.nearest_index !== e.nearest_index)
						report($sformatf("nearest_index got %0d want %0d",
							res.nearest_index, e.nearest_index));
					if (res.valid_res !== e.valid_res)
						report($sformatf("valid_res got %0b want %0b",
							res.valid_res, e.valid_res));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && ((start === 1'b1 && busy === 1'b0) || done === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		cmd_item_t          c;
		bit                 burst;
		bit                 big;
		bit                 pooled;
		int                 nload;
		int                 nq;
		int                 phase;
		int                 big_cnt;
		int                 off_sel;
		int                 k;
		logic signed [15:0] off_val;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		items_sent = 0;
		pt_cnt = 0;
		hoff = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(mk_row(OP_QUERY, 0, 0, 0, 1, 0, 0, 0));
		add_row(mk_row(OP_NOP, -1, -1, -1, 0, 0, 0, 0));
		add_row(mk_row(OP_LOAD, -32768, -32768, 32767, 0, 0, 0, 0));
		add_row(mk_row(OP_LOAD, 32767, 32767, -32768, 0, 0, 0, 0));
		add_row(mk_row(OP_QUERY, -32768, -32768, 0, 1, 32767, 0, 1));
		add_row(mk_row(OP_QUERY, 32767, 32767, 0, 1, -32768, 1, 1));
		add_row(mk_row(OP_QUERY, -32768, 32767, 0, 1, -32768, 1, 1));
		add_row(mk_row(OP_LOAD, 0, 0, 4660, 0, 0, 0, 0));
		add_row(mk_row(OP_LOAD, 0, 0, -5, 0, 0, 0, 0));
		add_row(mk_row(OP_QUERY, 0, 0, 12345, 1, -5, 3, 1));
		add_row(mk_row(OP_QUERY, 100, -100, 0, 0, 0, 0, 0));
		add_row(mk_row(OP_NOP, 5, 5, 5, 0, 0, 0, 0));
		add_row(mk_row(OP_QUERY, 1, 1, 0, 0, 0, 0, 0));
		add_row(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_row(OP_QUERY, 7, 7, 0, 1, 0, 0, 0));
		add_row(mk_row(OP_LOAD, 256, -256, 128, 0, 0, 0, 0));
		add_row(mk_row(OP_QUERY, -32768, 32767, 0, 1, 128, 0, 1));
		add_row(mk_row(OP_LOAD, -256, 256, -128, 0, 0, 0, 0));
		add_row(mk_row(OP_QUERY, 0, 0, 0, 1, -128, 1, 1));
		add_row(mk_row(OP_QUERY, 300, -300, 0, 0, 0, 0, 0));
		add_row(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));

		foreach (dir_tab[i])
			issue(dir_tab[i].c, $urandom_range(0, 15), dir_tab[i].typed, dir_tab[i].r);

		phase = 0;
		big_cnt = 0;
		off_sel = 0;
		while (items_sent < RUN_ITEMS) begin
			if (phase % 4 == 0) begin
				case (off_sel % 5)
					0: off_val = 16'sh7fff;
					1: off_val = 16'sh8000;
					2: off_val = 16'sh0000;
					3: off_val = 16'($urandom_range(0, 65535));
					default: off_val = 16'(int'($urandom_range(0, 1023)) - 512);
				endcase
				off_sel++;
				set_offset(off_val);
			end
			burst = ($urandom_range(0, 3) == 0);
			big = (phase == 3) || (big_cnt < 3 && $urandom_range(0, 39) == 0);
			pooled = ($urandom_range(0, 2) == 0);
			if (big) begin
				big_cnt++;
				nload = $urandom_range(250, 275);
				nq = $urandom_range(1, 3);
			end else begin
				nload = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
				nq = $urandom_range(1, 8);
			end
			if ($urandom_range(0, 5) != 0) begin
				c = '0;
				c.op = OP_CLEAR;
				c.pos_x = 16'($urandom_range(0, 65535));
				c.pos_y = 16'($urandom_range(0, 65535));
				c.pos_z = 16'($urandom_range(0, 65535));
				send_cmd(c, burst);
			end
			for (k = 0; k < nload; k++) begin
				c.op = OP_LOAD;
				c.pos_x = pick_coord(pooled);
				c.pos_y = pick_coord(pooled);
				c.pos_z = pick_coord(1'b0);
				send_cmd(c, burst);
			end
			for (k = 0; k < nq; k++) begin
				c.op = OP_QUERY;
				c.pos_z = 16'($urandom_range(0, 65535));
				if (pt_cnt != 0 && $urandom_range(0, 1) == 0) begin
					nload = $urandom_range(0, pt_cnt - 1);
					c.pos_x = pt_x[nload] + ($urandom_range(0, 1) ? 16'sd0 : 16'sd1);
					c.pos_y = pt_y[nload];
				end else begin
					c.pos_x = pick_coord(pooled);
					c.pos_y = pick_coord(pooled);
				end
				send_cmd(c, burst);
			end
			phase++;
		end

		@(negedge clk);
		start <= 1'b0;
		while (answers_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
